[design/rcdbus_pkg.sv]
// Shared types and constants of the remote control frame receiver.
package rcdbus_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int IDX_W       = $clog2(FRAME_BYTES + 1);
  localparam int TICK_W      = 16;
  localparam int CH_W        = 11;
  localparam int NUM_CH      = 4;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_W       = 120;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_IDLE = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } rcdbus_act_e;

  typedef enum logic [1:0] {
    LINK_VALID = 2'd0,
    LINK_WRONG = 2'd1,
    LINK_LOST  = 2'd2
  } rcdbus_link_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CH_MIN   = 3'd0,
    CFG_CH_MAX   = 3'd1,
    CFG_SW_UP    = 3'd2,
    CFG_SW_MID   = 3'd3,
    CFG_SW_DOWN  = 3'd4,
    CFG_TIMEOUT  = 3'd5
  } rcdbus_cfg_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic       is_byte;
    logic       is_idle;
    logic       is_tick;
    logic [7:0] data;
  } rcdbus_op_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] stick;
    logic [1:0]                  sw_left;
    logic [1:0]                  sw_right;
    logic [15:0]                 mouse_dx;
    logic [15:0]                 mouse_dy;
    logic [7:0]                  btn_left;
    logic [7:0]                  btn_right;
    logic [15:0]                 keys;
  } rcdbus_held_t;

endpackage

[design/rc_dbus_frame_receiver_unit.sv]
// Remote control frame receiver: takes bytes, bus-idle marks and ticks; reports
// the held frame and the link status. Every input transfer yields exactly one
// result transfer. The block sustains one item per clock while the output takes
// results: the back end updates all state and forms the result combinationally.
// An item passes from the input queue into the result register and then waits
// there until it is taken; while a result waits, the two-entry queue takes up to
// two more transfers before the input stalls.
module rc_dbus_frame_receiver_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // rx_byte[7:0]
  input  logic [1:0]                    s_axis_tuser,  // action[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // stick0, stick1, stick2, stick3, switch_left, switch_right, mouse_dx, mouse_dy,
  // button_left, button_right, key_bits, link_status, then zero fill
  output logic [rcdbus_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [rcdbus_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcdbus_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import rcdbus_pkg::*;

  logic       q_valid;
  logic       q_pop;
  rcdbus_op_t q_op;

  rcdbus_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_op_o        (q_op)
  );

  rcdbus_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_op_i        (q_op),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[design/rcdbus_front.sv]
// Input side: accept transfers, classify the action, and buffer them in a two-entry queue.
module rcdbus_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // rx_byte[7:0]
  input  logic [1:0]          s_axis_tuser,   // action[1:0]
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output rcdbus_pkg::rcdbus_op_t q_op_o
);
  import rcdbus_pkg::*;

  rcdbus_op_t op_in;
  rcdbus_op_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  always_comb begin
    op_in         = '0;
    op_in.data    = s_axis_tdata;
    case (rcdbus_act_e'(s_axis_tuser))
      ACT_BYTE: op_in.is_byte = 1'b1;
      ACT_IDLE: op_in.is_idle = 1'b1;
      ACT_TICK: op_in.is_tick = 1'b1;
      default:  op_in.is_byte = 1'b0;
    endcase
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (count_q != 2'd0);
  assign q_op_o        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, q_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[design/rcdbus_back.sv]
// Execution side: frame buffer, unpack and check, tick counters, link judgment, result register.
module rcdbus_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  rcdbus_pkg::rcdbus_op_t        q_op_i,
  input  logic                          cfg_we_i,
  input  logic [rcdbus_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcdbus_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rcdbus_pkg::OUT_W-1:0]  m_axis_tdata
);
  import rcdbus_pkg::*;

  // configuration
  logic [CH_W-1:0]   ch_min_q, ch_max_q;
  logic [1:0]        sw_up_q, sw_mid_q, sw_down_q;
  logic [TICK_W-1:0] timeout_q;

  // state
  logic [7:0]        fb_q [FRAME_BYTES];
  logic [IDX_W-1:0]  idx_q;
  rcdbus_held_t      held_q, held_d;
  logic [TICK_W-1:0] tsf_q, tsf_d, tsv_q, tsv_d;
  rcdbus_link_e      link_q, link_d;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  logic [47:0]       lo;
  logic [CH_W-1:0]   ch [NUM_CH];
  logic              frame_ok;
  logic              sw_l_ok, sw_r_ok;
  rcdbus_held_t      unpacked;
  logic [TICK_W-1:0] tsf_inc, tsv_inc, tick_gap;

  assign q_pop_o       = q_valid_i && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // unpack the frame, LSB first
  always_comb begin
    lo = {fb_q[5], fb_q[4], fb_q[3], fb_q[2], fb_q[1], fb_q[0]};
    frame_ok = 1'b1;
    unpacked = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      ch[k] = lo[CH_W*k +: CH_W];
      if (ch[k] < ch_min_q || ch[k] > ch_max_q) begin
        frame_ok = 1'b0;
      end
      // subtracting the center only flips the top bit
      unpacked.stick[k] = ch[k] ^ {1'b1, {(CH_W-1){1'b0}}};
    end
    unpacked.sw_left   = lo[45:44];
    unpacked.sw_right  = lo[47:46];
    sw_l_ok = (lo[45:44] == sw_up_q) || (lo[45:44] == sw_mid_q) || (lo[45:44] == sw_down_q);
    sw_r_ok = (lo[47:46] == sw_up_q) || (lo[47:46] == sw_mid_q) || (lo[47:46] == sw_down_q);
    if (!sw_l_ok || !sw_r_ok) begin
      frame_ok = 1'b0;
    end
    unpacked.mouse_dx  = {fb_q[7], fb_q[6]};
    unpacked.mouse_dy  = {fb_q[9], fb_q[8]};
    unpacked.btn_left  = fb_q[12];
    unpacked.btn_right = fb_q[13];
    unpacked.keys      = {fb_q[15], fb_q[14]};
  end

  always_comb begin
    tsf_inc  = (tsf_q != '1) ? tsf_q + 1'b1 : tsf_q;
    tsv_inc  = (tsv_q != '1) ? tsv_q + 1'b1 : tsv_q;
    tick_gap = tsv_inc - tsf_inc;

    held_d = held_q;
    tsf_d  = tsf_q;
    tsv_d  = tsv_q;
    link_d = link_q;
    if (q_op_i.is_idle) begin
      tsf_d = '0;
      if (frame_ok) begin
        held_d = unpacked;
        tsv_d  = '0;
      end
    end else if (q_op_i.is_tick) begin
      tsf_d = tsf_inc;
      tsv_d = tsv_inc;
      if (tsf_inc > timeout_q) begin
        link_d = LINK_LOST;
      end else if (tick_gap > timeout_q) begin
        link_d = LINK_WRONG;
      end else begin
        link_d = LINK_VALID;
      end
    end

    // result fields read zero unless the link is valid
    if (link_d == LINK_VALID) begin
      out_data_d = {6'b0, link_d, held_d.keys, held_d.btn_right, held_d.btn_left,
                    held_d.mouse_dy, held_d.mouse_dx, held_d.sw_right, held_d.sw_left,
                    held_d.stick[3], held_d.stick[2], held_d.stick[1], held_d.stick[0]};
    end else begin
      out_data_d = {6'b0, link_d, {(OUT_W-8){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_min_q    <= 11'd364;
      ch_max_q    <= 11'd1684;
      sw_up_q     <= 2'd1;
      sw_mid_q    <= 2'd3;
      sw_down_q   <= 2'd2;
      timeout_q   <= 16'd100;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        fb_q[i] <= '0;
      end
      idx_q       <= '0;
      held_q      <= '0;
      tsf_q       <= '0;
      tsv_q       <= '1;
      link_q      <= LINK_WRONG;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (rcdbus_cfg_e'(cfg_idx_i))
          CFG_CH_MIN:  ch_min_q  <= cfg_wdata_i[CH_W-1:0];
          CFG_CH_MAX:  ch_max_q  <= cfg_wdata_i[CH_W-1:0];
          CFG_SW_UP:   sw_up_q   <= cfg_wdata_i[1:0];
          CFG_SW_MID:  sw_mid_q  <= cfg_wdata_i[1:0];
          CFG_SW_DOWN: sw_down_q <= cfg_wdata_i[1:0];
          CFG_TIMEOUT: timeout_q <= cfg_wdata_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
        tsf_q       <= tsf_d;
        tsv_q       <= tsv_d;
        link_q      <= link_d;
        if (q_op_i.is_idle) begin
          idx_q <= '0;
        end else if (q_op_i.is_byte && idx_q < IDX_W'(FRAME_BYTES)) begin
          fb_q[idx_q] <= q_op_i.data;
          idx_q       <= idx_q + 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[test/tb_rc_dbus_frame_receiver_unit.sv]
// Self-checking testbench of the remote control frame receiver: random and directed streams.
module tb_rc_dbus_frame_receiver_unit;
  import rcdbus_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 6;
  localparam int NUM_FIELDS   = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // rx_byte[7:0]
  logic [1:0]           s_axis_tuser  = '0;  // action[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // stick0, stick1, stick2, stick3, switch_left, switch_right, mouse_dx, mouse_dy,
  // button_left, button_right, key_bits, link_status, then zero fill
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;

  rc_dbus_frame_receiver_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Result field layout, lowest bit up
  string fld_name [NUM_FIELDS] = '{"stick0", "stick1", "stick2", "stick3", "switch_left",
                                   "switch_right", "mouse_dx", "mouse_dy", "button_left",
                                   "button_right", "key_bits", "link_status", "zero_fill"};
  int    fld_lsb  [NUM_FIELDS] = '{0, 11, 22, 33, 44, 46, 48, 64, 80, 88, 96, 112, 114};
  int    fld_w    [NUM_FIELDS] = '{11, 11, 11, 11, 2, 2, 16, 16, 8, 8, 16, 2, 6};

  // Predictor state
  logic [7:0]             rx_frame [FRAME_BYTES];
  int                     rx_count;
  logic [3:0][CH_W-1:0]   held_stick;
  logic [1:0]             held_sw_l, held_sw_r;
  logic [15:0]            held_dx, held_dy, held_keys;
  logic [7:0]             held_btn_l, held_btn_r;
  logic [TICK_W-1:0]      ticks_frame, ticks_valid;
  rcdbus_link_e           link_now;
  logic [CH_W-1:0]        lim_min, lim_max;
  logic [1:0]             code_up, code_mid, code_down;
  logic [15:0]            tmo_ticks;

  logic [OUT_W-1:0]       exp_frames [$];
  logic [OUT_W-1:0]       want_frame;
  int                     items_done;
  int                     mismatch_cnt;
  int                     cycle_cnt;
  int                     src_gap_pct;
  int                     snk_stall_pct;
  int                     hold_reqs;
  int                     hold_served;
  int                     hold_left;

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    if (mismatch_cnt < 100)
      $display("mismatch %s at cycle %0d: got %0h want %0h", what, cycle_cnt, got, want);
    mismatch_cnt++;
  endtask

  task automatic reset_link_model();
    foreach (rx_frame[i]) rx_frame[i] = '0;
    rx_count    = 0;
    held_stick  = '0;
    held_sw_l   = '0;
    held_sw_r   = '0;
    held_dx     = '0;
    held_dy     = '0;
    held_keys   = '0;
    held_btn_l  = '0;
    held_btn_r  = '0;
    ticks_frame = '0;
    ticks_valid = '1;
    link_now    = LINK_WRONG;
    lim_min     = 11'd364;
    lim_max     = 11'd1684;
    code_up     = 2'd1;
    code_mid    = 2'd3;
    code_down   = 2'd2;
    tmo_ticks   = 16'd100;
  endtask

  function automatic bit switch_ok(logic [1:0] s);
    return s == code_up || s == code_mid || s == code_down;
  endfunction

  task automatic close_frame();
    logic [47:0]          lo;
    logic [CH_W-1:0]      ch;
    logic [3:0][CH_W-1:0] centred;
    bit                   ok;
    lo = {rx_frame[5], rx_frame[4], rx_frame[3], rx_frame[2], rx_frame[1], rx_frame[0]};
    rx_count    = 0;
    ticks_frame = '0;
    ok          = 1'b1;
    for (int k = 0; k < NUM_CH; k++) begin
      ch = lo[CH_W*k +: CH_W];
      if (ch < lim_min || ch > lim_max) ok = 1'b0;
      centred[k] = ch - 11'd1024;
    end
    if (!switch_ok(lo[45:44]) || !switch_ok(lo[47:46])) ok = 1'b0;
    // Invalid frames leave the held frame and the valid-age counter alone
    if (ok) begin
      held_stick  = centred;
      held_sw_l   = lo[45:44];
      held_sw_r   = lo[47:46];
      held_dx     = {rx_frame[7], rx_frame[6]};
      held_dy     = {rx_frame[9], rx_frame[8]};
      held_btn_l  = rx_frame[12];
      held_btn_r  = rx_frame[13];
      held_keys   = {rx_frame[15], rx_frame[14]};
      ticks_valid = '0;
    end
  endtask

  task automatic advance_tick();
    if (ticks_frame != '1) ticks_frame++;
    if (ticks_valid != '1) ticks_valid++;
    if (ticks_frame > tmo_ticks)
      link_now = LINK_LOST;
    else if (int'(ticks_valid) - int'(ticks_frame) > int'(tmo_ticks))
      link_now = LINK_WRONG;
    else
      link_now = LINK_VALID;
  endtask

  task automatic predict_result(rcdbus_act_e act, logic [7:0] data);
    logic [OUT_W-1:0] r;
    case (act)
      ACT_BYTE: begin
        if (rx_count < FRAME_BYTES) begin
          rx_frame[rx_count] = data;
          rx_count++;
        end
      end
      ACT_IDLE: begin
        close_frame();
      end
      ACT_TICK: begin
        advance_tick();
      end
      default: ;
    endcase
    items_done++;
    r = '0;
    if (link_now == LINK_VALID) begin
      r[43:0]   = held_stick;
      r[45:44]  = held_sw_l;
      r[47:46]  = held_sw_r;
      r[63:48]  = held_dx;
      r[79:64]  = held_dy;
      r[87:80]  = held_btn_l;
      r[95:88]  = held_btn_r;
      r[111:96] = held_keys;
    end
    r[113:112] = link_now;
    exp_frames.push_back(r);
  endtask

  // Output side: check each transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_frames.size() == 0) begin
        report_mismatch("unexpected", m_axis_tdata, '0);
      end else begin
        want_frame = exp_frames.pop_front();
        for (int f = 0; f < NUM_FIELDS; f++) begin
          if ((((m_axis_tdata ^ want_frame) >> fld_lsb[f]) &
               ((120'd1 << fld_w[f]) - 1)) !== '0)
            report_mismatch(fld_name[f], m_axis_tdata, want_frame);
        end
      end
    end
  end

  // Receiver: drive tready for the next edge, with long holds on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_served   <= hold_served + 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(rcdbus_act_e act, logic [7:0] data);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_result(act, data);
  endtask

  task automatic send_frame(logic [143:0] frm, int nbytes, bit close);
    for (int i = 0; i < nbytes; i++)
      send_item(ACT_BYTE, (i < FRAME_BYTES) ? frm[8*i +: 8] : 8'($urandom));
    if (close) send_item(ACT_IDLE, 8'($urandom));
  endtask

  function automatic logic [143:0] make_frame(logic [3:0][CH_W-1:0] ch, logic [1:0] s1,
                                              logic [1:0] s2, logic [95:0] tail);
    return {tail, s2, s1, ch};
  endfunction

  // Wait for every expected result, then let the pipeline settle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (exp_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (rcdbus_cfg_e'(idx))
      CFG_CH_MIN:  lim_min   = val[CH_W-1:0];
      CFG_CH_MAX:  lim_max   = val[CH_W-1:0];
      CFG_SW_UP:   code_up   = val[1:0];
      CFG_SW_MID:  code_mid  = val[1:0];
      CFG_SW_DOWN: code_down = val[1:0];
      CFG_TIMEOUT: tmo_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [15:0] ch_lo, logic [15:0] ch_hi, logic [15:0] up,
                            logic [15:0] mid, logic [15:0] down, logic [15:0] tmo);
    wait_drain();
    write_register(CFG_CH_MIN, ch_lo);
    write_register(CFG_CH_MAX, ch_hi);
    write_register(CFG_SW_UP, up);
    write_register(CFG_SW_MID, mid);
    write_register(CFG_SW_DOWN, down);
    write_register(CFG_TIMEOUT, tmo);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 39))
      0: return lim_min;
      1: return lim_max;
      2: return lim_min - 11'd1;
      3: return lim_max + 11'd1;
      4: return CH_W'($urandom);
      default: begin
        if (lim_min <= lim_max) return CH_W'($urandom_range(int'(lim_min), int'(lim_max)));
        return CH_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [1:0] pick_switch();
    if ($urandom_range(0, 15) == 0) return 2'($urandom);
    case ($urandom_range(0, 2))
      0:       return code_up;
      1:       return code_mid;
      default: return code_down;
    endcase
  endfunction

  // Mostly well-formed frames followed by ticks; the rest is noise
  task automatic rand_sequence();
    logic [3:0][CH_W-1:0] ch;
    int                   nb;
    int                   nt;
    if ($urandom_range(0, 99) < 75) begin
      for (int k = 0; k < NUM_CH; k++) ch[k] = pick_channel();
      nb = FRAME_BYTES;
      case ($urandom_range(0, 9))
        0: nb = $urandom_range(1, FRAME_BYTES - 1);
        1: nb = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 3);
        default: ;
      endcase
      send_frame(make_frame(ch, pick_switch(), pick_switch(), {$urandom, $urandom, $urandom}),
                 nb, $urandom_range(0, 19) != 0);
      nt = $urandom_range(0, 3);
      // Occasionally run the tick counters up to the timeout (capped at 150) or a little past it
      if ($urandom_range(0, 11) == 0)
        nt = ((tmo_ticks > 16'd150) ? 150 : int'(tmo_ticks)) + $urandom_range(0, 3);
      repeat (nt) send_item(ACT_TICK, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) send_item(rcdbus_act_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic run_random(int n);
    int goal;
    goal = items_done + n;
    while (items_done < goal) rand_sequence();
  endtask

  task automatic test_directed_defaults();
    logic [143:0] frm;
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    frm = make_frame({11'd1023, 11'd1024, 11'd1684, 11'd364}, 2'd1, 2'd2,
                     {16'h0000, 16'hA5C3, 8'h00, 8'hFF, 16'hFFFF, 16'h7FFF, 16'h8000});
    send_item(ACT_TICK, 8'h00);
    // One byte past the end of the buffer is dropped
    send_frame(frm, FRAME_BYTES + 1, 1'b1);
    send_item(ACT_TICK, 8'hFF);
    send_item(ACT_NONE, 8'hFF);
    // Short frame: only byte 0 is replaced, which pulls stick0 below the window
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_IDLE, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_BYTE, 8'h6C);
    send_item(ACT_IDLE, 8'hFF);
  endtask

  task automatic test_open_limits();
    // Upper bits of the write data are dropped by the register widths
    set_limits(16'h0000, 16'hFFFF, 16'hFFFC, 16'h0000, 16'h0000, 16'd1);
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    run_random(200);
  endtask

  task automatic test_tight_limits();
    set_limits(16'd1000, 16'd1100, 16'd1, 16'd2, 16'd3, 16'd5);
    src_gap_pct   = 51;
    snk_stall_pct = 0;
    run_random(200);
  endtask

  task automatic test_empty_window();
    // Minimum above maximum accepts nothing; a zero timeout loses the link on any tick
    set_limits(16'd2047, 16'd0, 16'd3, 16'd3, 16'd3, 16'd0);
    src_gap_pct   = 0;
    snk_stall_pct = 51;
    run_random(150);
  endtask

  task automatic test_long_timeout();
    set_limits(16'd364, 16'd1684, 16'd0, 16'd3, 16'd2, 16'hFFFF);
    src_gap_pct   = 36;
    snk_stall_pct = 36;
    run_random(200);
  endtask

  task automatic test_output_stall();
    wait_drain();
    write_register(CFG_SPARE_LO, 16'hFFFF);
    write_register(CFG_SPARE_HI, 16'h0000);
    cfg_we_i <= 1'b0;
    set_limits(16'd364, 16'd1684, 16'd1, 16'd3, 16'd2, 16'd8);
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    // Hold the output off while the input keeps offering, so the block backs up
    hold_reqs++;
    run_random(40);
    wait_drain();
    src_gap_pct   = 36;
    snk_stall_pct = 36;
    run_random(260);
  endtask

  initial begin
    items_done    = 0;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    hold_reqs     = 0;
    hold_served   = 0;
    hold_left     = 0;
    reset_link_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_open_limits();
    test_tight_limits();
    test_empty_window();
    test_long_timeout();
    test_output_stall();
    wait_drain();
    if (mismatch_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
design/rcdbus_pkg.sv
design/rcdbus_front.sv
design/rcdbus_back.sv
design/rc_dbus_frame_receiver_unit.sv
test/tb_rc_dbus_frame_receiver_unit.sv
